@@ sv/sdm_pkg.sv @@
// Shared types, codes and helpers for the single-wire debug host.
package sdm_pkg;

	// Width of every timing register.
	localparam int unsigned CFG_W = 16;
	// Width of the register index on the configuration port.
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

	// Reset values of the timing registers.
	localparam logic [CFG_W-1:0] RST_SHORT_LOW = 16'd9;
	localparam logic [CFG_W-1:0] RST_LONG_LOW  = 16'd48;
	localparam logic [CFG_W-1:0] RST_GAP       = 16'd9;
	localparam logic [CFG_W-1:0] RST_THRESHOLD = 16'd8;
	localparam logic [CFG_W-1:0] RST_TIMEOUT   = 16'd144;

	// Operation codes of an input beat. Code 3 behaves as a tick.
	localparam int unsigned OP_W = 2;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Link phase.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TX_LOW  = 3'd1,
		PH_TX_GAP  = 3'd2,
		PH_RX_LOW  = 3'd3,
		PH_RX_WAIT = 3'd4
	} phase_t;

	// Timing registers as seen by the engine.
	typedef struct packed {
		logic [CFG_W-1:0] short_low;
		logic [CFG_W-1:0] long_low;
		logic [CFG_W-1:0] gap;
		logic [CFG_W-1:0] threshold;
		logic [CFG_W-1:0] timeout;
	} cfg_t;

	// Single-bit result flags of one beat.
	typedef struct packed {
		logic drive_low;
		logic busy;
		logic done;
		logic ok;
		logic rejected;
	} flags_t;

	// A length of zero counts as one tick.
	function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
		return (v == '0) ? CFG_W'(1) : v;
	endfunction

endpackage

@@ sv/sdm_cfg.sv @@
// Timing register file of the single-wire debug host.
module sdm_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [sdm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [sdm_pkg::CFG_W-1:0]          wr_data,
	output sdm_pkg::cfg_t                      cfg
);

	sdm_pkg::cfg_t cfg_q;

	// Register writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_low <= sdm_pkg::RST_SHORT_LOW;
			cfg_q.long_low  <= sdm_pkg::RST_LONG_LOW;
			cfg_q.gap       <= sdm_pkg::RST_GAP;
			cfg_q.threshold <= sdm_pkg::RST_THRESHOLD;
			cfg_q.timeout   <= sdm_pkg::RST_TIMEOUT;
		end else if (wr_en) begin
			case (wr_index)
				sdm_pkg::REG_SHORT_LOW: cfg_q.short_low <= wr_data;
				sdm_pkg::REG_LONG_LOW:  cfg_q.long_low  <= wr_data;
				sdm_pkg::REG_GAP:       cfg_q.gap       <= wr_data;
				sdm_pkg::REG_THRESHOLD: cfg_q.threshold <= wr_data;
				sdm_pkg::REG_TIMEOUT:   cfg_q.timeout   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/sdm_engine.sv @@
// Link state machine: advances the transfer by one beat per step strobe.
module sdm_engine #(
	parameter int unsigned ADDR_BITS = 7,
	parameter int unsigned DATA_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [sdm_pkg::OP_W-1:0]      op,
	input  logic                          line_level,
	input  logic [ADDR_BITS-1:0]          address,
	input  logic [DATA_BITS-1:0]          write_data,
	input  sdm_pkg::cfg_t                 cfg,
	output sdm_pkg::flags_t               flags,
	output logic [DATA_BITS-1:0]          read_data
);

	localparam int unsigned HDR_BITS   = ADDR_BITS + 2;
	localparam int unsigned FRAME_BITS = HDR_BITS + DATA_BITS;
	localparam int unsigned BIDX_W     = $clog2(FRAME_BITS + 1);
	localparam int unsigned CW         = sdm_pkg::CFG_W;

	localparam logic [BIDX_W-1:0] HDR_COUNT   = BIDX_W'(HDR_BITS);
	localparam logic [BIDX_W-1:0] FRAME_COUNT = BIDX_W'(FRAME_BITS);
	localparam logic [BIDX_W-1:0] DATA_COUNT  = BIDX_W'(DATA_BITS);

	sdm_pkg::phase_t         phase_q, phase_d;
	logic [CW-1:0]           tick_q, tick_d;
	logic [BIDX_W-1:0]       bit_q, bit_d;
	logic [FRAME_BITS-1:0]   frame_q, frame_d;
	logic [DATA_BITS-1:0]    rx_q, rx_d;
	logic                    is_read_q, is_read_d;

	logic                    is_cmd;
	logic [CW:0]             tick_inc;
	logic [CW-1:0]           low_lim;
	logic                    low_end, gap_end, rx_low_end;
	logic [BIDX_W-1:0]       bit_inc;
	logic                    last_tx_bit, last_rx_bit;
	logic                    timed_out;
	logic                    rx_bit;
	logic [DATA_BITS-1:0]    rx_shifted;
	logic                    done, ok, rej;

	// Shared conditions of the current beat.
	assign is_cmd      = (op == sdm_pkg::OP_WRITE) || (op == sdm_pkg::OP_READ);
	assign tick_inc    = {1'b0, tick_q} + (CW+1)'(1);
	assign low_lim     = frame_q[FRAME_BITS-1] ? cfg.short_low : cfg.long_low;
	assign low_end     = tick_inc >= {1'b0, sdm_pkg::at_least_one(low_lim)};
	assign gap_end     = tick_inc >= {1'b0, sdm_pkg::at_least_one(cfg.gap)};
	assign rx_low_end  = tick_inc >= {1'b0, sdm_pkg::at_least_one(cfg.short_low)};
	assign bit_inc     = bit_q + BIDX_W'(1);
	assign last_tx_bit = bit_inc >= (is_read_q ? HDR_COUNT : FRAME_COUNT);
	assign last_rx_bit = bit_inc >= DATA_COUNT;
	assign timed_out   = tick_q >= cfg.timeout;
	assign rx_bit      = tick_q < cfg.threshold;
	assign rx_shifted  = {rx_q[DATA_BITS-2:0], rx_bit};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (is_cmd) begin
			if (phase_q == sdm_pkg::PH_IDLE) begin
				phase_d = sdm_pkg::PH_TX_LOW;
			end
		end else begin
			case (phase_q)
				sdm_pkg::PH_IDLE: phase_d = sdm_pkg::PH_IDLE;
				sdm_pkg::PH_TX_LOW: begin
					if (low_end) phase_d = sdm_pkg::PH_TX_GAP;
				end
				sdm_pkg::PH_TX_GAP: begin
					if (gap_end) begin
						if (!last_tx_bit)   phase_d = sdm_pkg::PH_TX_LOW;
						else if (is_read_q) phase_d = sdm_pkg::PH_RX_LOW;
						else                phase_d = sdm_pkg::PH_IDLE;
					end
				end
				sdm_pkg::PH_RX_LOW: begin
					if (rx_low_end) phase_d = sdm_pkg::PH_RX_WAIT;
				end
				sdm_pkg::PH_RX_WAIT: begin
					if (line_level) begin
						phase_d = last_rx_bit ? sdm_pkg::PH_IDLE : sdm_pkg::PH_RX_LOW;
					end else if (timed_out) begin
						phase_d = sdm_pkg::PH_IDLE;
					end
				end
				default: phase_d = sdm_pkg::PH_IDLE;
			endcase
		end
	end

	// Counters, shift registers and result flags.
	always_comb begin
		tick_d    = tick_q;
		bit_d     = bit_q;
		frame_d   = frame_q;
		rx_d      = rx_q;
		is_read_d = is_read_q;
		done      = 1'b0;
		ok        = 1'b0;
		rej       = 1'b0;
		if (is_cmd) begin
			if (phase_q != sdm_pkg::PH_IDLE) begin
				rej = 1'b1;
			end else begin
				is_read_d = (op == sdm_pkg::OP_READ);
				frame_d   = {1'b1, address, !is_read_d,
				             is_read_d ? {DATA_BITS{1'b0}} : write_data};
				bit_d     = '0;
				tick_d    = '0;
				rx_d      = '0;
			end
		end else begin
			case (phase_q)
				sdm_pkg::PH_TX_LOW: begin
					tick_d = low_end ? '0 : tick_inc[CW-1:0];
				end
				sdm_pkg::PH_TX_GAP: begin
					tick_d = gap_end ? '0 : tick_inc[CW-1:0];
					if (gap_end) begin
						frame_d = {frame_q[FRAME_BITS-2:0], 1'b0};
						if (!last_tx_bit) begin
							bit_d = bit_inc;
						end else begin
							bit_d = '0;
							done  = !is_read_q;
						end
					end
				end
				sdm_pkg::PH_RX_LOW: begin
					tick_d = rx_low_end ? '0 : tick_inc[CW-1:0];
				end
				sdm_pkg::PH_RX_WAIT: begin
					if (line_level) begin
						rx_d   = rx_shifted;
						tick_d = '0;
						if (last_rx_bit) begin
							bit_d = '0;
							done  = 1'b1;
							ok    = 1'b1;
						end else begin
							bit_d = bit_inc;
						end
					end else if (timed_out) begin
						tick_d = '0;
						bit_d  = '0;
						done   = 1'b1;
					end else begin
						tick_d = tick_inc[CW-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Result of this beat, taken from the phase it leaves behind.
	always_comb begin
		flags.drive_low = (phase_d == sdm_pkg::PH_TX_LOW) || (phase_d == sdm_pkg::PH_RX_LOW);
		flags.busy      = phase_d != sdm_pkg::PH_IDLE;
		flags.done      = done;
		flags.ok        = ok;
		flags.rejected  = rej;
		read_data       = ok ? rx_shifted : '0;
	end

	// Link state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sdm_pkg::PH_IDLE;
			tick_q    <= '0;
			bit_q     <= '0;
			frame_q   <= '0;
			rx_q      <= '0;
			is_read_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_q     <= bit_d;
			frame_q   <= frame_d;
			rx_q      <= rx_d;
			is_read_q <= is_read_d;
		end
	end

endmodule

@@ sv/single_wire_debug_master_core.sv @@
// Top level of the single-wire debug host: beat registers around the link engine.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one beat per timer tick or
//   command: op selects a tick, a write start or a read start; line_level is
//   the wire sampled at that tick; address and write_data go with a command.
//   Each input beat yields exactly one output beat (out_valid / out_stall)
//   with the wire drive, busy, done, read status, read word and reject flag.
//   Timing registers are written through wr_en / wr_index / wr_data; the user must
//   do so only while the host is idle (not enforced); indexes 5 to 7 are ignored.
// Pipeline and throughput:
//   A beat is captured in the input register, stepped through the engine and
//   held in the output register. One beat is taken every cycle while no held
//   result is stalled, set by the single engine update.
// Reset:
//   arst_n clears both beat registers, idles the link and loads default timings.
// Stall:
//   While out_stall holds a result, the engine freezes and the input register
//   still takes one more beat; once it is full, in_stall rises.
module single_wire_debug_master_core #(
	parameter int unsigned ADDR_BITS = 7,
	parameter int unsigned DATA_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sdm_pkg::OP_W-1:0]           op,
	input  logic                               line_level,
	input  logic [ADDR_BITS-1:0]               address,
	input  logic [DATA_BITS-1:0]               write_data,
	// Output channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               drive_low,
	output logic                               busy_res,
	output logic                               done_res,
	output logic                               read_ok,
	output logic [DATA_BITS-1:0]               read_data,
	output logic                               rejected,
	// Configuration port.
	input  logic                               wr_en,
	input  logic [sdm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [sdm_pkg::CFG_W-1:0]          wr_data
);

	sdm_pkg::cfg_t               cfg;
	sdm_pkg::flags_t             flags;
	logic [DATA_BITS-1:0]        rdata;

	logic                        valid_s1;
	logic [sdm_pkg::OP_W-1:0]    op_s1;
	logic                        level_s1;
	logic [ADDR_BITS-1:0]        addr_s1;
	logic [DATA_BITS-1:0]        wdata_s1;

	logic                        valid_s2;
	sdm_pkg::flags_t             flags_s2;
	logic [DATA_BITS-1:0]        rdata_s2;

	logic                        adv_s2, adv_s1, step;

	// Handshake: the output register moves unless a held result is stalled.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign step     = valid_s1 && adv_s2;
	assign in_stall = !adv_s1;

	sdm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Input beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1    <= op;
			level_s1 <= line_level;
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
	end

	sdm_engine #(
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (DATA_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.op         (op_s1),
		.line_level (level_s1),
		.address    (addr_s1),
		.write_data (wdata_s1),
		.cfg        (cfg),
		.flags      (flags),
		.read_data  (rdata)
	);

	// Output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			flags_s2 <= flags;
			rdata_s2 <= rdata;
		end
	end

	assign out_valid = valid_s2;
	assign drive_low = flags_s2.drive_low;
	assign busy_res  = flags_s2.busy;
	assign done_res  = flags_s2.done;
	assign read_ok   = flags_s2.ok;
	assign read_data = rdata_s2;
	assign rejected  = flags_s2.rejected;

`ifndef NO_ASSERTIONS
	// A finished transfer leaves the link idle and released.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !drive_low)
		else $error("transfer finished while link still busy");

	// A good read status only comes with the finishing beat.
	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_ok |-> done_res && !rejected)
		else $error("read status without finished transfer");

	// The read word is zero unless a read completed.
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_ok |-> read_data == '0)
		else $error("read word nonzero without completed read");

	// A command is rejected only while the link is busy; it leaves the link busy and unfinished.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !done_res)
		else $error("command rejected while link idle");

	// A stalled engine holds its state, so the input side must stall once full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ bench/single_wire_debug_master_core_tb.sv @@
// Self-checking bench for the single-wire debug host core.
`timescale 1ns / 1ps

module single_wire_debug_master_core_tb;

	localparam int ADDR_W  = 7;
	localparam int DATA_W  = 32;
	localparam int HDR_W   = ADDR_W + 2;
	localparam int FRAME_W = HDR_W + DATA_W;
	localparam int IDX_W   = sdm_pkg::CFG_IDX_W;
	localparam int REG_W   = sdm_pkg::CFG_W;
	// Op code 3 is unused and acts as a plain tick.
	localparam logic [sdm_pkg::OP_W-1:0] OP_SPARE = 2'd3;
	// Register index past the last timing register.
	localparam logic [IDX_W-1:0] REG_NONE_LO = 3'd5;
	localparam logic [IDX_W-1:0] REG_NONE_HI = 3'd7;
	localparam int LIMIT_NS = 12 * 2_000_000;

	// One input beat.
	typedef struct packed {
		logic [sdm_pkg::OP_W-1:0] op;
		logic                     lvl;
		logic [ADDR_W-1:0]        addr;
		logic [DATA_W-1:0]        wd;
	} beat_t;

	// One result beat.
	typedef struct packed {
		logic              drive_low;
		logic              busy;
		logic              done;
		logic              ok;
		logic [DATA_W-1:0] rdata;
		logic              rej;
	} outcome_t;

	// Link state of the host.
	typedef struct packed {
		sdm_pkg::phase_t   ph;
		logic [16:0]       tcnt;
		logic [5:0]        bidx;
		logic [HDR_W-1:0]  hdr;
		logic [DATA_W-1:0] dat;
		logic [DATA_W-1:0] rx;
		logic              rd;
	} link_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [sdm_pkg::OP_W-1:0] op = sdm_pkg::OP_TICK;
	logic line_level = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic drive_low, busy_res, done_res, read_ok, rejected;
	logic [DATA_W-1:0] read_data;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [REG_W-1:0] wr_data = '0;

	single_wire_debug_master_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .line_level(line_level), .address(address), .write_data(write_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.drive_low(drive_low), .busy_res(busy_res), .done_res(done_res),
		.read_ok(read_ok), .read_data(read_data), .rejected(rejected),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// Beats waiting to be sent and results waiting to arrive.
	beat_t    pending[$];
	outcome_t expected_res[$];

	// Link copy that scores accepted beats, and one that steers the stimulus.
	link_t score_st = '0;
	link_t plan_st  = '0;
	sdm_pkg::cfg_t score_cfg = {sdm_pkg::RST_SHORT_LOW, sdm_pkg::RST_LONG_LOW,
		sdm_pkg::RST_GAP, sdm_pkg::RST_THRESHOLD, sdm_pkg::RST_TIMEOUT};
	sdm_pkg::cfg_t plan_cfg  = {sdm_pkg::RST_SHORT_LOW, sdm_pkg::RST_LONG_LOW,
		sdm_pkg::RST_GAP, sdm_pkg::RST_THRESHOLD, sdm_pkg::RST_TIMEOUT};

	int unsigned slot_wait = 0;
	bit abort_next = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int calm_tx = 0;
	int calm_rx = 0;
	int mismatches = 0;
	int n_in = 0, n_out = 0, n_writes = 0, n_good_reads = 0, n_aborts = 0;
	int n_rejects = 0, n_reg_writes = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#LIMIT_NS;
		$display("tb: failure");
		$finish;
	end

	// A zero length counts as one tick.
	function automatic int unsigned floor_one(input int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	// Advances the link by one beat and returns the result it gives.
	function automatic outcome_t link_step(inout link_t s, input sdm_pkg::cfg_t c,
			input beat_t b);
		outcome_t r;
		logic [FRAME_W-1:0] frame;
		int unsigned lim;
		int nbits;
		r = '0;
		if (b.op == sdm_pkg::OP_WRITE || b.op == sdm_pkg::OP_READ) begin
			if (s.ph != sdm_pkg::PH_IDLE) begin
				r.rej = 1'b1;
			end else begin
				s.rd   = (b.op == sdm_pkg::OP_READ);
				s.hdr  = {1'b1, b.addr, ~s.rd};
				s.dat  = s.rd ? '0 : b.wd;
				s.bidx = '0;
				s.tcnt = '0;
				s.rx   = '0;
				s.ph   = sdm_pkg::PH_TX_LOW;
			end
		end else begin
			case (s.ph)
				sdm_pkg::PH_TX_LOW: begin
					frame = {s.hdr, s.dat};
					lim = frame[FRAME_W-1-s.bidx] ? c.short_low : c.long_low;
					s.tcnt = s.tcnt + 17'd1;
					if (s.tcnt >= floor_one(lim)) begin
						s.tcnt = '0;
						s.ph = sdm_pkg::PH_TX_GAP;
					end
				end
				sdm_pkg::PH_TX_GAP: begin
					nbits = s.rd ? HDR_W : FRAME_W;
					s.tcnt = s.tcnt + 17'd1;
					if (s.tcnt >= floor_one(c.gap)) begin
						s.tcnt = '0;
						s.bidx = s.bidx + 6'd1;
						if (s.bidx < nbits) begin
							s.ph = sdm_pkg::PH_TX_LOW;
						end else if (s.rd) begin
							s.bidx = '0;
							s.ph = sdm_pkg::PH_RX_LOW;
						end else begin
							s.bidx = '0;
							r.done = 1'b1;
							s.ph = sdm_pkg::PH_IDLE;
						end
					end
				end
				sdm_pkg::PH_RX_LOW: begin
					s.tcnt = s.tcnt + 17'd1;
					if (s.tcnt >= floor_one(c.short_low)) begin
						s.tcnt = '0;
						s.ph = sdm_pkg::PH_RX_WAIT;
					end
				end
				sdm_pkg::PH_RX_WAIT: begin
					if (b.lvl) begin
						s.rx = {s.rx[DATA_W-2:0], (s.tcnt < c.threshold)};
						s.tcnt = '0;
						s.bidx = s.bidx + 6'd1;
						if (s.bidx >= DATA_W) begin
							s.bidx = '0;
							r.done = 1'b1;
							r.ok = 1'b1;
							r.rdata = s.rx;
							s.ph = sdm_pkg::PH_IDLE;
						end else begin
							s.ph = sdm_pkg::PH_RX_LOW;
						end
					end else if (s.tcnt >= c.timeout) begin
						s.tcnt = '0;
						s.bidx = '0;
						r.done = 1'b1;
						s.ph = sdm_pkg::PH_IDLE;
					end else begin
						s.tcnt = s.tcnt + 17'd1;
					end
				end
				default: s.ph = sdm_pkg::PH_IDLE;
			endcase
		end
		r.drive_low = (s.ph == sdm_pkg::PH_TX_LOW || s.ph == sdm_pkg::PH_RX_LOW);
		r.busy = (s.ph != sdm_pkg::PH_IDLE);
		return r;
	endfunction

	// Returns the timings with one register replaced; other indexes change nothing.
	function automatic sdm_pkg::cfg_t with_reg(input sdm_pkg::cfg_t c,
			input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		case (idx)
			sdm_pkg::REG_SHORT_LOW: c.short_low = val;
			sdm_pkg::REG_LONG_LOW:  c.long_low = val;
			sdm_pkg::REG_GAP:       c.gap = val;
			sdm_pkg::REG_THRESHOLD: c.threshold = val;
			sdm_pkg::REG_TIMEOUT:   c.timeout = val;
			default: ;
		endcase
		return c;
	endfunction

	// Chooses how long the line stays low in the next read slot.
	function automatic int unsigned pick_wait(input sdm_pkg::cfg_t c);
		int unsigned t;
		int unsigned cap;
		cap = (c.timeout < 40) ? c.timeout : 40;
		if ((abort_next || $urandom_range(199) == 0) && c.timeout < 300) begin
			abort_next = 1'b0;
			return c.timeout + 1;
		end
		case ($urandom_range(7))
			0: t = 0;
			1: t = c.threshold;
			2: t = (c.threshold == 0) ? 0 : c.threshold - 1;
			3: t = c.threshold + 1;
			4: t = c.timeout;
			default: t = $urandom_range(cap);
		endcase
		if (t > 300) t = $urandom_range(cap);
		if (t > c.timeout) t = c.timeout;
		return t;
	endfunction

	function automatic beat_t make_tick();
		beat_t b;
		b.op = ($urandom_range(29) == 0) ? OP_SPARE : sdm_pkg::OP_TICK;
		b.addr = ADDR_W'($urandom);
		b.wd = $urandom;
		if (plan_st.ph == sdm_pkg::PH_RX_WAIT) begin
			b.lvl = (plan_st.tcnt >= slot_wait);
			// Now and then a glitch breaks the slot timing.
			if ($urandom_range(39) == 0) b.lvl = 1'($urandom);
		end else begin
			b.lvl = 1'($urandom);
		end
		return b;
	endfunction

	function automatic beat_t make_cmd(input logic [sdm_pkg::OP_W-1:0] code);
		beat_t b;
		b.op = code;
		b.lvl = 1'($urandom);
		case ($urandom_range(4))
			0: b.addr = '0;
			1: b.addr = '1;
			default: b.addr = ADDR_W'($urandom);
		endcase
		case ($urandom_range(5))
			0: b.wd = '0;
			1: b.wd = '1;
			default: b.wd = $urandom;
		endcase
		return b;
	endfunction

	task automatic wait_quiet();
		while (pending.size() != 0 || expected_res.size() != 0) @(negedge clk);
	endtask

	// Queues a beat and advances the steering copy of the link.
	task automatic push_beat(input beat_t b);
		sdm_pkg::phase_t prev;
		while (pending.size() >= 16) @(negedge clk);
		pending.push_back(b);
		prev = plan_st.ph;
		void'(link_step(plan_st, plan_cfg, b));
		if (plan_st.ph == sdm_pkg::PH_RX_WAIT && prev != sdm_pkg::PH_RX_WAIT)
			slot_wait = pick_wait(plan_cfg);
	endtask

	// Runs one command to its end, optionally with a second command while busy.
	task automatic run_cmd(input logic [sdm_pkg::OP_W-1:0] code, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, input bit poke);
		beat_t b;
		int k;
		b = make_cmd(code);
		b.addr = a;
		b.wd = d;
		push_beat(b);
		k = 0;
		while (plan_st.ph != sdm_pkg::PH_IDLE) begin
			if (poke && k == 5)
				push_beat(make_cmd((code == sdm_pkg::OP_READ) ? sdm_pkg::OP_WRITE
					: sdm_pkg::OP_READ));
			else push_beat(make_tick());
			k++;
		end
	endtask

	// Writes a timing register once the link is idle and every result is in.
	task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		while (plan_st.ph != sdm_pkg::PH_IDLE) push_beat(make_tick());
		wait_quiet();
		repeat (4) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		plan_cfg = with_reg(plan_cfg, idx, val);
		score_cfg = with_reg(score_cfg, idx, val);
		n_reg_writes++;
	endtask

	task automatic set_timing(input int unsigned sl, input int unsigned ll, input int unsigned g,
			input int unsigned th, input int unsigned tm);
		set_reg(sdm_pkg::REG_SHORT_LOW, REG_W'(sl));
		set_reg(sdm_pkg::REG_LONG_LOW, REG_W'(ll));
		set_reg(sdm_pkg::REG_GAP, REG_W'(g));
		set_reg(sdm_pkg::REG_THRESHOLD, REG_W'(th));
		set_reg(sdm_pkg::REG_TIMEOUT, REG_W'(tm));
	endtask

	task automatic random_timing();
		set_timing($urandom_range(4),
			($urandom_range(9) == 0) ? 40 : $urandom_range(10),
			$urandom_range(4), $urandom_range(8),
			($urandom_range(4) == 0) ? 200 : $urandom_range(24));
		if ($urandom_range(3) == 0)
			set_reg(IDX_W'($urandom_range(REG_NONE_HI, REG_NONE_LO)), REG_W'($urandom));
	endtask

	// Random traffic: mostly complete transfers, plus stray commands and spare ticks.
	task automatic feed(input int n);
		beat_t b;
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(599) == 0) wait_quiet();
			b = make_tick();
			if (plan_st.ph == sdm_pkg::PH_IDLE) begin
				if ($urandom_range(9) != 0)
					b = make_cmd($urandom_range(1) ? sdm_pkg::OP_READ : sdm_pkg::OP_WRITE);
			end else if ($urandom_range(49) == 0) begin
				b = make_cmd($urandom_range(1) ? sdm_pkg::OP_READ : sdm_pkg::OP_WRITE);
			end
			push_beat(b);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (mismatches < 40)
			$display("mismatch: %s on result %0d, got %0h, wanted %0h", what, n_out, got, want);
		mismatches++;
	endtask

	// Input driver: presents the oldest pending beat and scores it when it is taken.
	always @(posedge clk) begin : drive_proc
		bit take;
		bit go;
		outcome_t e;
		if (arst_n) begin
			take = in_valid && !in_stall;
			if (take) begin
				e = link_step(score_st, score_cfg, pending[0]);
				expected_res.push_back(e);
				void'(pending.pop_front());
				n_in++;
				if (e.rej) n_rejects++;
				if (e.done && !score_st.rd) n_writes++;
				if (e.done && e.ok) n_good_reads++;
				if (e.done && !e.ok && score_st.rd) n_aborts++;
			end
			if (calm_tx > 0) calm_tx--;
			else if ($urandom_range(199) == 0) calm_tx = $urandom_range(60, 20);
			if (!in_valid || take) begin
				go = (pending.size() != 0) &&
					(calm_tx > 0 || $urandom_range(99) >= send_idle_pct);
				in_valid <= go;
				if (go) begin
					op <= pending[0].op;
					line_level <= pending[0].lvl;
					address <= pending[0].addr;
					write_data <= pending[0].wd;
				end
			end
		end
	end

	// Output monitor: checks every result beat against the oldest expectation.
	always @(posedge clk) begin : watch_proc
		outcome_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected beat", '0, '0);
				end else begin
					want = expected_res.pop_front();
					if (drive_low !== want.drive_low)
						report_mismatch("drive_low", drive_low, want.drive_low);
					if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
					if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
					if (read_ok !== want.ok) report_mismatch("read_ok", read_ok, want.ok);
					if (read_data !== want.rdata)
						report_mismatch("read_data", read_data, want.rdata);
					if (rejected !== want.rej) report_mismatch("rejected", rejected, want.rej);
				end
				n_out++;
			end
			if (calm_rx > 0) calm_rx--;
			else if ($urandom_range(199) == 0) calm_rx = $urandom_range(60, 20);
			out_stall <= (calm_rx == 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Stimulus sequence.
	initial begin : stim_proc
		int ph_i;
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset timings, then tight timings with every command shape.
		run_cmd(sdm_pkg::OP_READ, 7'h7F, '0, 1'b0);
		set_timing(1, 2, 1, 2, 6);
		push_beat(make_tick());
		run_cmd(sdm_pkg::OP_WRITE, 7'h00, 32'h0000_0000, 1'b0);
		run_cmd(sdm_pkg::OP_WRITE, 7'h7F, 32'hFFFF_FFFF, 1'b0);
		run_cmd(sdm_pkg::OP_WRITE, 7'h55, 32'hA5A5_0F0F, 1'b1);
		run_cmd(sdm_pkg::OP_READ, 7'h2A, 32'h1234_5678, 1'b1);
		abort_next = 1'b1;
		run_cmd(sdm_pkg::OP_READ, 7'h01, '0, 1'b0);

		// Zero lengths act as one tick; a zero threshold reads every slot as 0.
		set_timing(0, 0, 0, 0, 0);
		run_cmd(sdm_pkg::OP_READ, 7'h40, '0, 1'b0);
		run_cmd(sdm_pkg::OP_WRITE, 7'h3C, 32'h8000_0001, 1'b0);
		abort_next = 1'b1;
		run_cmd(sdm_pkg::OP_READ, 7'h7E, '0, 1'b0);

		// Largest threshold and timeout; the all-ones write never uses the long pulse.
		set_timing(3, 65535, 2, 65535, 65535);
		set_reg(REG_NONE_HI, 16'hFFFF);
		set_reg(REG_NONE_LO, 16'h0000);
		run_cmd(sdm_pkg::OP_WRITE, 7'h7F, 32'hFFFF_FFFF, 1'b0);
		// A read header always ends in a 0 bit, so the long pulse is shortened first.
		set_reg(sdm_pkg::REG_LONG_LOW, 16'd5);
		run_cmd(sdm_pkg::OP_READ, 7'h11, '0, 1'b0);

		// Random traffic under four idling regimes.
		for (ph_i = 0; ph_i < 4; ph_i++) begin
			case (ph_i)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			random_timing();
			feed(30);
			// Hold the sender off in mid-transfer until everything is back.
			wait_quiet();
			feed(30);
		end

		// Drain and let the pipeline settle.
		for (k = 0; k < 200000 && (pending.size() != 0 || expected_res.size() != 0); k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_res.size() != 0) report_mismatch("results never arrived", '0, '0);

		$display("covered %0d beats in, %0d out, %0d register writes under four idling regimes",
			n_in, n_out, n_reg_writes);
		$display("transfers: %0d writes, %0d good reads, %0d aborted reads, %0d rejected commands",
			n_writes, n_good_reads, n_aborts, n_rejects);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
